FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the timed wait queue datapath.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant that holds at every clock edge outside reset.
`define TWQ_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("twq invariant violated");

// Implication checked at every clock edge outside reset.
`define TWQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("twq implication violated");

`endif

FILE: rtl/twq_pkg.sv
// ----------------------------------------------------------------------------
// twq_pkg
// Types and constants of the timed wait queue.
// ----------------------------------------------------------------------------
package twq_pkg;

  localparam int DEPTH   = 16;
  localparam int ID_BITS = 8;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_TICK   = 2'd1;
  localparam logic [1:0] FUNC_GET    = 2'd2;

  localparam logic [2:0] KIND_INSERTED = 3'd0;
  localparam logic [2:0] KIND_FULL     = 3'd1;
  localparam logic [2:0] KIND_RELEASED = 3'd2;
  localparam logic [2:0] KIND_REMOVED  = 3'd3;
  localparam logic [2:0] KIND_NOTHING  = 3'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  process_id;
    logic [15:0] wait_ticks;
  } twq_in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] released_id;
    logic       sem_credit;
    logic       last;
    logic [4:0] queue_length;
  } twq_out_t;

  typedef struct packed {
    logic single;
    logic scan_init;
    logic pop;
    logic finish;
  } twq_cmd_t;

  typedef struct packed {
    logic scan_done;
  } twq_stat_t;

endpackage

FILE: rtl/twq_ctrl.sv
// ----------------------------------------------------------------------------
// twq_ctrl
// Controller: decodes commands and sequences the tick pass.
// ----------------------------------------------------------------------------
module twq_ctrl
  import twq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] func,
  input  twq_stat_t  stat,
  output twq_cmd_t   ctl,
  output logic       busy
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (func == FUNC_TICK) begin
            ctl.scan_init = 1'b1;
            state_next    = ST_SCAN;
          end else begin
            ctl.single = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          ctl.finish = 1'b1;
          state_next = ST_IDLE;
        end else begin
          ctl.pop = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state == ST_SCAN);

endmodule

FILE: rtl/twq_dp.sv
// ----------------------------------------------------------------------------
// twq_dp
// Datapath: entry shift line, counters, pending release and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module twq_dp
  import twq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  twq_in_t   cmd,
  input  twq_cmd_t  ctl,
  input  logic      cfg_we,
  input  logic      cfg_bit,
  output twq_stat_t stat,
  output twq_out_t  result,
  output logic      result_valid
);

  logic [ID_BITS-1:0] ids   [DEPTH];
  logic [15:0]        waits [DEPTH];
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   remain;
  logic               pend_valid;
  logic [ID_BITS-1:0] pend_id;
  logic [CNT_W-1:0]   pend_len;
  logic               sem_linked;
  twq_out_t           res;
  logic               res_valid;

  logic               head_rel;
  logic [IDX_W-1:0]   tail_idx;

  assign head_rel       = (waits[0] <= 16'd1);
  assign tail_idx       = IDX_W'(cnt - 1'b1);
  assign stat.scan_done = (remain == '0);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      remain     <= '0;
      pend_valid <= 1'b0;
      sem_linked <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      if (cfg_we) begin
        sem_linked <= cfg_bit;
      end
      if (ctl.single) begin
        res_valid <= 1'b1;
        if (cmd.func == FUNC_INSERT && cnt != CNT_W'(DEPTH)) begin
          cnt <= cnt + 1'b1;
        end else if (cmd.func == FUNC_GET && cnt != '0) begin
          cnt <= cnt - 1'b1;
        end
      end
      if (ctl.scan_init) begin
        remain     <= cnt;
        pend_valid <= 1'b0;
      end
      if (ctl.pop) begin
        remain <= remain - 1'b1;
        if (head_rel) begin
          cnt        <= cnt - 1'b1;
          pend_valid <= 1'b1;
          res_valid  <= pend_valid;
        end
      end
      if (ctl.finish) begin
        pend_valid <= 1'b0;
        res_valid  <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.single) begin
      res <= '{kind: KIND_NOTHING, released_id: 8'd0, sem_credit: 1'b0,
               last: 1'b1, queue_length: 5'(cnt)};
      case (cmd.func)
        FUNC_INSERT: begin
          if (cnt == CNT_W'(DEPTH)) begin
            res.kind <= KIND_FULL;
          end else begin
            ids[IDX_W'(cnt)]   <= ID_BITS'(cmd.process_id);
            waits[IDX_W'(cnt)] <= cmd.wait_ticks;
            res.kind           <= KIND_INSERTED;
            res.queue_length   <= 5'(cnt + 1'b1);
          end
        end
        FUNC_GET: begin
          if (cnt != '0) begin
            for (int k = 0; k < DEPTH - 1; k++) begin
              ids[k]   <= ids[k+1];
              waits[k] <= waits[k+1];
            end
            res.kind         <= KIND_REMOVED;
            res.released_id  <= 8'(ids[0]);
            res.queue_length <= 5'(cnt - 1'b1);
          end
        end
        default: begin
        end
      endcase
    end
    if (ctl.pop) begin
      for (int k = 0; k < DEPTH - 1; k++) begin
        ids[k]   <= ids[k+1];
        waits[k] <= waits[k+1];
      end
      if (head_rel) begin
        res      <= '{kind: KIND_RELEASED, released_id: 8'(pend_id),
                      sem_credit: sem_linked, last: 1'b0,
                      queue_length: 5'(pend_len)};
        pend_id  <= ids[0];
        pend_len <= cnt - 1'b1;
      end else begin
        ids[tail_idx]   <= ids[0];
        waits[tail_idx] <= waits[0] - 16'd1;
      end
    end
    if (ctl.finish) begin
      if (pend_valid) begin
        res <= '{kind: KIND_RELEASED, released_id: 8'(pend_id),
                 sem_credit: sem_linked, last: 1'b1,
                 queue_length: 5'(pend_len)};
      end else begin
        res <= '{kind: KIND_NOTHING, released_id: 8'd0, sem_credit: 1'b0,
                 last: 1'b1, queue_length: 5'(cnt)};
      end
    end
  end

  assign result       = res;
  assign result_valid = res_valid;

  `TWQ_ASSERT(a_cnt_bound, cnt <= CNT_W'(DEPTH))
  `TWQ_ASSERT(a_remain_le_cnt, remain <= cnt)
  `TWQ_ASSERT_IMP(a_mid_release_pending,
    res_valid && res.kind == KIND_RELEASED && !res.last, pend_valid)
  `TWQ_ASSERT_IMP(a_other_kinds_last,
    res_valid && res.kind != KIND_RELEASED, res.last)

endmodule

FILE: rtl/timed_wait_queue_core.sv
// ----------------------------------------------------------------------------
// timed_wait_queue_core
// Timeout wait queue: insert, tick release in arrival order, get oldest.
//
//   channel   signals                       transfer when
//   command   start, busy, cmd              start && !busy
//   result    result_valid, result          result_valid (one cycle)
//   config    cfg_valid, cfg_ready, cfg_data cfg_valid && cfg_ready
//
// Insert, get and unused codes: result in the cycle after start; busy stays low.
// Tick with N entries held: busy high, one pop of the head per cycle, then
// a finish step; releases appear in order, the last one after the final pop.
// Synchronous reset empties the queue and clears sem_linked.
// Results cannot be stalled; config is taken whenever busy is low.
// ----------------------------------------------------------------------------
module timed_wait_queue_core
  import twq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  twq_in_t  cmd,
  output logic     result_valid,
  output twq_out_t result,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data
);

  twq_cmd_t  ctl;
  twq_stat_t stat;

  assign cfg_ready = !busy;

  twq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .func (cmd.func),
    .stat (stat),
    .ctl  (ctl),
    .busy (busy)
  );

  twq_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .ctl         (ctl),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_bit     (cfg_data),
    .stat        (stat),
    .result      (result),
    .result_valid(result_valid)
  );

endmodule
